>>> sv/assert_macros.svh
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at each rising edge, off while in reset
`define CBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at each rising edge, reset included
`define CBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Types and codes of the counted blinker controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

    typedef logic [1:0] op_t;
    typedef logic [1:0] start_mode_t;
    typedef logic [1:0] stop_mode_t;
    typedef logic [2:0] break_mode_t;
    typedef logic [2:0] cfg_index_t;

    localparam int CFG_DATA_W = 24;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // item operations
    localparam op_t OP_TICK     = 2'd0;
    localparam op_t OP_SWITCH   = 2'd1;
    localparam op_t OP_COUNTED  = 2'd2;
    localparam op_t OP_FEEDBACK = 2'd3;

    // start modes
    localparam start_mode_t START_OFF     = 2'd0;
    localparam start_mode_t START_ON      = 2'd1;
    localparam start_mode_t START_INVERSE = 2'd2;
    localparam start_mode_t START_KEEP    = 2'd3;

    // stop modes
    localparam stop_mode_t STOP_OFF      = 2'd0;
    localparam stop_mode_t STOP_ON       = 2'd1;
    localparam stop_mode_t STOP_PREVIOUS = 2'd2;
    localparam stop_mode_t STOP_INVERSE  = 2'd3;

    // break modes
    localparam break_mode_t BRK_IGNORE  = 3'd0;
    localparam break_mode_t BRK_ON      = 3'd1;
    localparam break_mode_t BRK_OFF     = 3'd2;
    localparam break_mode_t BRK_RESTORE = 3'd3;
    localparam break_mode_t BRK_INVERSE = 3'd4;
    localparam break_mode_t BRK_SILENT  = 3'd5;
    localparam break_mode_t BRK_UNUSED6 = 3'd6;
    localparam break_mode_t BRK_UNUSED7 = 3'd7;

    // register indexes
    localparam cfg_index_t REG_BLINK_COUNT     = 3'd0;
    localparam cfg_index_t REG_ON_TIME_MS      = 3'd1;
    localparam cfg_index_t REG_OFF_TIME_MS     = 3'd2;
    localparam cfg_index_t REG_START_MODE      = 3'd3;
    localparam cfg_index_t REG_STOP_MODE       = 3'd4;
    localparam cfg_index_t REG_BREAK_MODE      = 3'd5;
    localparam cfg_index_t REG_BREAK_MODE_HOLD = 3'd6;
    localparam cfg_index_t REG_LEVELS          = 3'd7;

    localparam logic [23:0] ELAPSED_MAX   = 24'hFF_FFFF;
    localparam logic [7:0]  ENDLESS_COUNT = 8'd255;

endpackage

>>> sv/cbc_in_if.sv
// ----------------------------------------------------------------------------
// cbc_in_if
// Input item channel: telegrams, feedback values and ticks.
// ----------------------------------------------------------------------------
interface cbc_in_if;

    logic              valid;
    logic              ready;
    cbc_pkg::op_t      op;
    logic [7:0]        value;
    logic [15:0]       tick_ms;

    modport source (output valid, output op, output value, output tick_ms, input ready);
    modport sink (input valid, input op, input value, input tick_ms, output ready);

endinterface

>>> sv/cbc_out_if.sv
// ----------------------------------------------------------------------------
// cbc_out_if
// Result item channel: output level and blinking-active telegrams.
// ----------------------------------------------------------------------------
interface cbc_out_if;

    logic       valid;
    logic       ready;
    logic       send_output;
    logic [7:0] output_level;
    logic       send_active;
    logic       active;

    modport source (output valid, output send_output, output output_level,
                    output send_active, output active, input ready);
    modport sink (input valid, input send_output, input output_level,
                  input send_active, input active, output ready);

endinterface

>>> sv/counted_blinker_controller_core.sv
// an accepted item passes the input register, then the result register
// throughput: one item per cycle while the result channel is ready, set
//   by the single state update between the input and result registers
// reset: asynchronous, active low; configuration and state registers return
//   to their defaults and the blinker state is cleared
// ----------------------------------------------------------------------------
// counted_blinker_controller_core
// Counted blinker: start/stop and counted-start telegrams, feedback values
// and elapsed-time ticks in; output level and active flag telegrams out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module counted_blinker_controller_core #(
    parameter bit PERCENT_OUTPUT = 1'b0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cbc_pkg::cfg_index_t   cfg_index,
    input  cbc_pkg::cfg_data_t    cfg_data,
    cbc_in_if.sink                in_ch,
    cbc_out_if.source             out_ch
);

    // configuration
    logic [7:0]                blink_count_reg;
    logic [23:0]               on_time_ms_reg;
    logic [23:0]               off_time_ms_reg;
    cbc_pkg::start_mode_t      start_mode_reg;
    cbc_pkg::stop_mode_t       stop_mode_reg;
    cbc_pkg::break_mode_t      break_mode_reg;
    cbc_pkg::break_mode_t      break_mode_hold_reg;
    logic [15:0]               levels_reg;

    // input stage
    logic                      in_valid_reg;
    cbc_pkg::op_t              op_reg;
    logic [7:0]                value_reg;
    logic [15:0]               tick_ms_reg;

    // blinker state
    logic                      running_reg, running_next;
    logic                      phase_on_reg, phase_on_next;
    logic [8:0]                half_phases_left_reg, half_phases_left_next;
    logic [23:0]               phase_elapsed_reg, phase_elapsed_next;
    logic [7:0]                start_value_reg, start_value_next;
    logic [7:0]                known_level_reg, known_level_next;
    logic                      level_known_reg, level_known_next;

    // result register
    logic                      out_valid_reg;
    logic                      send_output_reg, send_output_next;
    logic [7:0]                output_level_reg, output_level_next;
    logic                      send_active_reg, send_active_next;
    logic                      active_reg, active_next;

    logic                      advance;

    // helpers
    logic [7:0]                on_lvl;
    logic [7:0]                off_lvl;
    logic [7:0]                restore_lvl;
    logic                      inverse_on;
    logic [7:0]                cur_value;
    logic                      cur_on;
    logic                      new_phase;
    logic [7:0]                start_count;
    logic                      do_start;
    logic                      do_break;
    logic                      trim;
    logic [8:0]                count2;
    cbc_pkg::break_mode_t      brk_mode;
    logic [24:0]               sum;
    logic [23:0]               sat;
    logic [23:0]               len;
    logic [8:0]                hpl_dec;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.send_output  = send_output_reg;
    assign out_ch.output_level = output_level_reg;
    assign out_ch.send_active  = send_active_reg;
    assign out_ch.active       = active_reg;

    assign on_lvl      = PERCENT_OUTPUT ? levels_reg[15:8] : 8'd1;
    assign off_lvl     = PERCENT_OUTPUT ? levels_reg[7:0] : 8'd0;
    assign restore_lvl = PERCENT_OUTPUT ? start_value_reg
                                        : {7'd0, (start_value_reg != 8'd0)};
    assign inverse_on  = PERCENT_OUTPUT ? (start_value_reg == levels_reg[7:0])
                                        : (start_value_reg == 8'd0);

    // current output state seen at start
    always_comb
    begin
        if (level_known_reg)
        begin
            cur_value = PERCENT_OUTPUT ? known_level_reg : {7'd0, known_level_reg[0]};
        end
        else
        begin
            cur_value = off_lvl;
        end
        cur_on = PERCENT_OUTPUT ? (cur_value != levels_reg[7:0]) : (cur_value != 8'd0);
    end

    // first phase from the start mode
    always_comb
    begin
        unique case (start_mode_reg)
            cbc_pkg::START_OFF:     new_phase = 1'b0;
            cbc_pkg::START_ON:      new_phase = 1'b1;
            cbc_pkg::START_INVERSE: new_phase = !cur_on;
            cbc_pkg::START_KEEP:    new_phase = phase_on_reg;
        endcase
    end

    always_comb
    begin
        unique case (stop_mode_reg)
            cbc_pkg::STOP_OFF:      trim = new_phase;
            cbc_pkg::STOP_ON:       trim = !new_phase;
            cbc_pkg::STOP_PREVIOUS: trim = (new_phase != cur_on);
            cbc_pkg::STOP_INVERSE:  trim = (new_phase == cur_on);
        endcase
    end

    assign start_count = (op_reg == cbc_pkg::OP_SWITCH) ? blink_count_reg : value_reg;
    assign count2      = {start_count, 1'b0};
    assign brk_mode    = (blink_count_reg == 8'd0) ? break_mode_hold_reg : break_mode_reg;

    assign sum     = {1'b0, phase_elapsed_reg} + {9'd0, tick_ms_reg};
    assign sat     = sum[24] ? cbc_pkg::ELAPSED_MAX : sum[23:0];
    assign len     = phase_on_reg ? on_time_ms_reg : off_time_ms_reg;
    assign hpl_dec = half_phases_left_reg - 9'd1;

    // start or break requested by this item
    always_comb
    begin
        do_start = 1'b0;
        do_break = 1'b0;
        case (op_reg)
            cbc_pkg::OP_SWITCH:
            begin
                do_start = value_reg[0];
                do_break = !value_reg[0];
            end
            cbc_pkg::OP_COUNTED:
            begin
                if (!(blink_count_reg == 8'd0 && half_phases_left_reg == 9'd0 && running_reg))
                begin
                    do_start = (value_reg != 8'd0);
                    do_break = (value_reg == 8'd0);
                end
            end
            default:
            begin
            end
        endcase
    end

    // state update and result for one item
    always_comb
    begin
        running_next          = running_reg;
        phase_on_next         = phase_on_reg;
        half_phases_left_next = half_phases_left_reg;
        phase_elapsed_next    = phase_elapsed_reg;
        start_value_next      = start_value_reg;
        known_level_next      = known_level_reg;
        level_known_next      = level_known_reg;
        send_output_next      = 1'b0;
        output_level_next     = 8'd0;
        send_active_next      = 1'b0;
        active_next           = 1'b0;

        if (do_start)
        begin
            start_value_next   = cur_value;
            running_next       = 1'b1;
            phase_elapsed_next = 24'd0;
            phase_on_next      = new_phase;
            if (blink_count_reg != cbc_pkg::ENDLESS_COUNT
                && (blink_count_reg != 8'd0 || start_count != 8'd0))
            begin
                half_phases_left_next = (trim && count2 != 9'd0) ? count2 - 9'd1 : count2;
            end
            else
            begin
                half_phases_left_next = 9'd0;
            end
            send_active_next  = 1'b1;
            active_next       = 1'b1;
            send_output_next  = 1'b1;
            output_level_next = new_phase ? on_lvl : off_lvl;
        end
        else if (do_break)
        begin
            case (brk_mode) inside
                cbc_pkg::BRK_ON, cbc_pkg::BRK_OFF, cbc_pkg::BRK_RESTORE,
                cbc_pkg::BRK_INVERSE, cbc_pkg::BRK_SILENT:
                begin
                    send_active_next      = 1'b1;
                    running_next          = 1'b0;
                    phase_elapsed_next    = 24'd0;
                    half_phases_left_next = 9'd0;
                end
                default:
                begin
                end
            endcase
            case (brk_mode)
                cbc_pkg::BRK_ON:
                begin
                    send_output_next  = 1'b1;
                    output_level_next = on_lvl;
                end
                cbc_pkg::BRK_OFF:
                begin
                    send_output_next  = 1'b1;
                    output_level_next = off_lvl;
                end
                cbc_pkg::BRK_RESTORE:
                begin
                    send_output_next  = 1'b1;
                    output_level_next = restore_lvl;
                end
                cbc_pkg::BRK_INVERSE:
                begin
                    send_output_next  = 1'b1;
                    output_level_next = inverse_on ? on_lvl : off_lvl;
                end
                default:
                begin
                end
            endcase
        end
        else if (op_reg == cbc_pkg::OP_FEEDBACK)
        begin
            if (blink_count_reg != cbc_pkg::ENDLESS_COUNT)
            begin
                known_level_next = PERCENT_OUTPUT ? value_reg : {7'd0, value_reg[0]};
                level_known_next = 1'b1;
            end
        end
        else if (op_reg == cbc_pkg::OP_TICK && running_reg)
        begin
            phase_elapsed_next = sat;
            if (sat >= len)
            begin
                phase_elapsed_next = sat - len;
                phase_on_next      = !phase_on_reg;
                send_output_next   = 1'b1;
                output_level_next  = !phase_on_reg ? on_lvl : off_lvl;
                if (half_phases_left_reg != 9'd0)
                begin
                    half_phases_left_next = hpl_dec;
                    if (hpl_dec == 9'd0)
                    begin
                        send_active_next   = 1'b1;
                        running_next       = 1'b0;
                        phase_elapsed_next = 24'd0;
                        unique case (stop_mode_reg)
                            cbc_pkg::STOP_OFF:      output_level_next = off_lvl;
                            cbc_pkg::STOP_ON:       output_level_next = on_lvl;
                            cbc_pkg::STOP_PREVIOUS: output_level_next = restore_lvl;
                            cbc_pkg::STOP_INVERSE:
                                output_level_next = inverse_on ? on_lvl : off_lvl;
                        endcase
                    end
                end
            end
        end

        if (send_output_next)
        begin
            known_level_next = output_level_next;
            level_known_next = 1'b1;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_count_reg     <= 8'd0;
            on_time_ms_reg      <= 24'd500;
            off_time_ms_reg     <= 24'd500;
            start_mode_reg      <= cbc_pkg::START_ON;
            stop_mode_reg       <= cbc_pkg::STOP_OFF;
            break_mode_reg      <= cbc_pkg::BRK_IGNORE;
            break_mode_hold_reg <= cbc_pkg::BRK_OFF;
            levels_reg          <= 16'd25600;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cbc_pkg::REG_BLINK_COUNT:     blink_count_reg     <= cfg_data[7:0];
                cbc_pkg::REG_ON_TIME_MS:      on_time_ms_reg      <= cfg_data[23:0];
                cbc_pkg::REG_OFF_TIME_MS:     off_time_ms_reg     <= cfg_data[23:0];
                cbc_pkg::REG_START_MODE:      start_mode_reg      <= cfg_data[1:0];
                cbc_pkg::REG_STOP_MODE:       stop_mode_reg       <= cfg_data[1:0];
                cbc_pkg::REG_BREAK_MODE:      break_mode_reg      <= cfg_data[2:0];
                cbc_pkg::REG_BREAK_MODE_HOLD: break_mode_hold_reg <= cfg_data[2:0];
                cbc_pkg::REG_LEVELS:          levels_reg          <= cfg_data[15:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg      <= in_ch.op;
            value_reg   <= in_ch.value;
            tick_ms_reg <= in_ch.tick_ms;
        end
    end

    // blinker state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg          <= 1'b0;
            phase_on_reg         <= 1'b0;
            half_phases_left_reg <= 9'd0;
            phase_elapsed_reg    <= 24'd0;
            start_value_reg      <= 8'd0;
            known_level_reg      <= 8'd0;
            level_known_reg      <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                running_reg          <= running_next;
                phase_on_reg         <= phase_on_next;
                half_phases_left_reg <= half_phases_left_next;
                phase_elapsed_reg    <= phase_elapsed_next;
                start_value_reg      <= start_value_next;
                known_level_reg      <= known_level_next;
                level_known_reg      <= level_known_next;
                out_valid_reg        <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            send_output_reg  <= send_output_next;
            output_level_reg <= output_level_next;
            send_active_reg  <= send_active_next;
            active_reg       <= active_next;
        end
    end

    `CBC_ASSERT_ALWAYS(a_idle_clear,
        !running_reg |-> (half_phases_left_reg == 9'd0 && phase_elapsed_reg == 24'd0),
        "idle blinker keeps a count or elapsed time")
    `CBC_ASSERT(a_quiet_fields,
        out_valid_reg |-> ((send_output_reg || output_level_reg == 8'd0)
                           && (send_active_reg || !active_reg)),
        "unsent result field not zero")
    `CBC_ASSERT(a_feedback_silent,
        (advance && op_reg == cbc_pkg::OP_FEEDBACK)
            |=> (out_valid_reg && !send_output_reg && !send_active_reg),
        "feedback item sent a telegram")
    `CBC_ASSERT_ALWAYS(a_switch_level,
        PERCENT_OUTPUT || known_level_reg[7:1] == 7'd0,
        "switch mode known level not a single bit")

endmodule
